/* sv/fgbq_pkg.sv */
// Package for the feature grid bucket query block.
// Holds shared constants, codes and the command type passed from front to back.
// No dependencies.
package fgbq_pkg;

    localparam int CELL_PIXELS_DEF   = 10;
    localparam int GRID_CELLS_DEF    = 200;
    localparam int CELL_CAPACITY_DEF = 8;
    localparam int MAX_HITS_DEF      = 64;

    localparam int COORD_W = 8;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 12;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_OUTSIDE = 3'd1,
        ST_FULL    = 3'd2,
        ST_HIT     = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_REJECT,
        OP_QEMPTY,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
    } t_cmd;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_CLR,
        B_INS_RD,
        B_INS_CHK,
        B_Q_RD,
        B_Q_CNT,
        B_Q_SLOT,
        B_Q_HIT,
        B_Q_END
    } t_bstate;

endpackage

/* sv/fgbq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fgbq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/fgbq_front.sv */
// Front end: accepts items, scales pixels to cells and classifies them into commands.
// Depends on fgbq_pkg.
module fgbq_front #(
    parameter int CELL_PIXELS = fgbq_pkg::CELL_PIXELS_DEF,
    parameter int GRID_CELLS  = fgbq_pkg::GRID_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hold,
    input  logic               start,
    input  logic [1:0]         i_mode,
    input  logic signed [12:0] i_u_pixel,
    input  logic signed [12:0] i_v_pixel,
    input  logic [10:0]        i_radius_pixels,
    output logic               o_busy,
    input  logic               i_q_full,
    output logic               o_push,
    output fgbq_pkg::t_cmd     o_cmd
);
    localparam int RECIP_SH = 20;
    localparam int RECIP    = (2**RECIP_SH + CELL_PIXELS - 1) / CELL_PIXELS;
    localparam int PW       = 33;

    logic          r_vld, n_vld;
    logic          r_ph, n_ph;
    logic [1:0]    r_mode;
    logic          r_neg;
    logic [11:0]   r_u, r_v;
    logic [10:0]   r_rad;
    logic [PW-1:0] r_pu, r_pv, r_pr;

    logic               accept;
    logic [12:0]        cx, cy, rc;
    logic signed [13:0] xl, xh, yl, yh, gmax;
    fgbq_pkg::t_cmd     cmd;

    assign accept = start && !o_busy;
    assign o_busy = r_vld || i_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ph  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_ph  <= n_ph;
        end
        if (accept) begin
            r_mode <= i_mode;
            r_neg  <= i_u_pixel[12] || i_v_pixel[12];
            r_u    <= i_u_pixel[11:0];
            r_v    <= i_v_pixel[11:0];
            r_rad  <= i_radius_pixels;
        end
        r_pu <= PW'(r_u) * PW'(RECIP);
        r_pv <= PW'(r_v) * PW'(RECIP);
        r_pr <= PW'(r_rad) * PW'(RECIP);
    end

    always_comb begin
        cx   = r_pu[RECIP_SH +: 13];
        cy   = r_pv[RECIP_SH +: 13];
        rc   = r_pr[RECIP_SH +: 13];
        gmax = 14'(GRID_CELLS - 1);
        xl   = $signed({1'b0, cx}) - $signed({1'b0, rc});
        xh   = $signed({1'b0, cx}) + $signed({1'b0, rc});
        yl   = $signed({1'b0, cy}) - $signed({1'b0, rc});
        yh   = $signed({1'b0, cy}) + $signed({1'b0, rc});
        cmd.op = fgbq_pkg::OP_CLEAR;
        cmd.x0 = cx[7:0];
        cmd.y0 = cy[7:0];
        cmd.x1 = (xh > gmax) ? gmax[7:0] : xh[7:0];
        cmd.y1 = (yh > gmax) ? gmax[7:0] : yh[7:0];
        unique case (r_mode)
            fgbq_pkg::MODE_INSERT: begin
                if (r_neg || cx >= 13'(GRID_CELLS) || cy >= 13'(GRID_CELLS)) begin
                    cmd.op = fgbq_pkg::OP_REJECT;
                end else begin
                    cmd.op = fgbq_pkg::OP_STORE;
                end
            end
            fgbq_pkg::MODE_QUERY: begin
                cmd.x0 = xl[13] ? '0 : xl[7:0];
                cmd.y0 = yl[13] ? '0 : yl[7:0];
                if (r_neg || xl > gmax || yl > gmax) begin
                    cmd.op = fgbq_pkg::OP_QEMPTY;
                end else begin
                    cmd.op = fgbq_pkg::OP_QUERY;
                end
            end
            default: cmd.op = fgbq_pkg::OP_CLEAR;
        endcase
    end

    always_comb begin
        n_vld  = r_vld;
        n_ph   = r_ph;
        o_push = 1'b0;
        if (accept) begin
            n_vld = (i_mode != fgbq_pkg::MODE_NONE);
            n_ph  = 1'b0;
        end else if (r_vld && !r_ph) begin
            n_ph = 1'b1;
        end else if (r_vld && r_ph && !i_q_full) begin
            o_push = 1'b1;
            n_vld  = 1'b0;
        end
    end

    assign o_cmd = cmd;
endmodule

/* sv/fgbq_queue.sv */
// Two-entry command queue between front and back.
// Depends on fgbq_pkg.
module fgbq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fgbq_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fgbq_pkg::t_cmd o_cmd
);
    fgbq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_q[r_rp];
endmodule

/* sv/fgbq_back.sv */
// Back end: runs commands against the fill-count and index RAMs, emits results.
// Depends on fgbq_pkg and fgbq_ram.
module fgbq_back #(
    parameter int GRID_CELLS    = fgbq_pkg::GRID_CELLS_DEF,
    parameter int CELL_CAPACITY = fgbq_pkg::CELL_CAPACITY_DEF,
    parameter int MAX_HITS      = fgbq_pkg::MAX_HITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fgbq_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_init,
    output logic           o_strobe,
    output logic [2:0]     o_status,
    output logic [11:0]    o_feature_index,
    output logic           o_last,
    output logic           o_truncated
);
    localparam int CELLS = GRID_CELLS * GRID_CELLS;
    localparam int AW    = $clog2(CELLS);
    localparam int SD    = CELLS * CELL_CAPACITY;
    localparam int SAW   = $clog2(SD);
    localparam int HW    = $clog2(MAX_HITS + 1);
    localparam int CW    = fgbq_pkg::COUNT_W;
    localparam int XW    = fgbq_pkg::COORD_W;
    localparam int IW    = fgbq_pkg::INDEX_W;

    fgbq_pkg::t_bstate r_state, n_state;
    fgbq_pkg::t_cmd    r_cmd, n_cmd;
    logic [IW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_addr, n_addr;
    logic [XW-1:0]     r_x, n_x, r_y, n_y;
    logic [AW-1:0]     r_c, n_c;
    logic [CW-1:0]     r_n, n_n, r_s, n_s;
    logic [HW-1:0]     r_hits, n_hits;
    logic              r_hold, n_hold;
    logic [IW-1:0]     r_hidx, n_hidx;
    logic              r_stb, n_stb;
    logic [2:0]        r_st, n_st;
    logic [IW-1:0]     r_fi, n_fi;
    logic              r_last, n_last, r_tr, n_tr;

    logic [AW-1:0]  cell_addr;
    logic           cnt_we;
    logic [AW-1:0]  cnt_waddr, cnt_raddr;
    logic [CW-1:0]  cnt_wdata, cnt_rdata, cnt_clamp;
    logic           sto_we;
    logic [SAW-1:0] sto_waddr, sto_raddr;
    logic [IW-1:0]  sto_rdata;

    fgbq_ram #(.W(CW), .D(CELLS)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    fgbq_ram #(.W(IW), .D(SD)) u_sto (
        .i_clk   (i_clk),
        .i_we    (sto_we),
        .i_waddr (sto_waddr),
        .i_wdata (r_idx),
        .i_raddr (sto_raddr),
        .o_rdata (sto_rdata)
    );

    assign cell_addr = AW'(32'(r_x) * GRID_CELLS + 32'(r_y));
    assign cnt_clamp = (cnt_rdata >= CW'(CELL_CAPACITY)) ? CW'(CELL_CAPACITY) : cnt_rdata;
    assign sto_waddr = SAW'(SAW'(r_c) * SAW'(CELL_CAPACITY) + SAW'(cnt_rdata));
    assign sto_raddr = SAW'(SAW'(r_c) * SAW'(CELL_CAPACITY) + SAW'(r_s));
    assign cnt_raddr = cell_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgbq_pkg::B_INIT;
            r_addr  <= '0;
            r_idx   <= '0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_idx   <= n_idx;
            r_stb   <= n_stb;
        end
        r_cmd  <= n_cmd;
        r_x    <= n_x;
        r_y    <= n_y;
        r_c    <= n_c;
        r_n    <= n_n;
        r_s    <= n_s;
        r_hits <= n_hits;
        r_hold <= n_hold;
        r_hidx <= n_hidx;
        r_st   <= n_st;
        r_fi   <= n_fi;
        r_last <= n_last;
        r_tr   <= n_tr;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_addr    = r_addr;
        n_x       = r_x;
        n_y       = r_y;
        n_c       = r_c;
        n_n       = r_n;
        n_s       = r_s;
        n_hits    = r_hits;
        n_hold    = r_hold;
        n_hidx    = r_hidx;
        n_stb     = 1'b0;
        n_st      = r_st;
        n_fi      = r_fi;
        n_last    = r_last;
        n_tr      = 1'b0;
        o_pop     = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = r_addr;
        cnt_wdata = '0;
        sto_we    = 1'b0;
        unique case (r_state) inside
            fgbq_pkg::B_INIT, fgbq_pkg::B_CLR: begin
                cnt_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = fgbq_pkg::B_IDLE;
                    if (r_state == fgbq_pkg::B_CLR) begin
                        n_idx  = '0;
                        n_stb  = 1'b1;
                        n_st   = fgbq_pkg::ST_CLEARED;
                        n_fi   = '0;
                        n_last = 1'b1;
                    end
                end
            end
            fgbq_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd;
                    n_x    = i_cmd.x0;
                    n_y    = i_cmd.y0;
                    n_hits = '0;
                    n_hold = 1'b0;
                    unique case (i_cmd.op)
                        fgbq_pkg::OP_STORE: n_state = fgbq_pkg::B_INS_RD;
                        fgbq_pkg::OP_REJECT: begin
                            n_stb  = 1'b1;
                            n_st   = fgbq_pkg::ST_OUTSIDE;
                            n_fi   = r_idx;
                            n_last = 1'b1;
                            n_idx  = r_idx + IW'(1);
                        end
                        fgbq_pkg::OP_QEMPTY: begin
                            n_stb  = 1'b1;
                            n_st   = fgbq_pkg::ST_EMPTY;
                            n_fi   = '0;
                            n_last = 1'b1;
                        end
                        fgbq_pkg::OP_QUERY: n_state = fgbq_pkg::B_Q_RD;
                        default: n_state = fgbq_pkg::B_CLR;
                    endcase
                end
            end
            fgbq_pkg::B_INS_RD: begin
                n_c     = cell_addr;
                n_state = fgbq_pkg::B_INS_CHK;
            end
            fgbq_pkg::B_INS_CHK: begin
                n_stb   = 1'b1;
                n_fi    = r_idx;
                n_last  = 1'b1;
                n_idx   = r_idx + IW'(1);
                n_state = fgbq_pkg::B_IDLE;
                if (cnt_rdata >= CW'(CELL_CAPACITY)) begin
                    n_st = fgbq_pkg::ST_FULL;
                end else begin
                    n_st      = fgbq_pkg::ST_STORED;
                    sto_we    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_waddr = r_c;
                    cnt_wdata = cnt_rdata + CW'(1);
                end
            end
            fgbq_pkg::B_Q_RD: begin
                n_c     = cell_addr;
                n_state = fgbq_pkg::B_Q_CNT;
            end
            fgbq_pkg::B_Q_CNT: begin
                n_n = cnt_clamp;
                n_s = '0;
                if (cnt_clamp != '0) begin
                    n_state = fgbq_pkg::B_Q_SLOT;
                end else if (r_y != r_cmd.y1) begin
                    n_y     = r_y + XW'(1);
                    n_state = fgbq_pkg::B_Q_RD;
                end else if (r_x != r_cmd.x1) begin
                    n_x     = r_x + XW'(1);
                    n_y     = r_cmd.y0;
                    n_state = fgbq_pkg::B_Q_RD;
                end else begin
                    n_state = fgbq_pkg::B_Q_END;
                end
            end
            fgbq_pkg::B_Q_SLOT: n_state = fgbq_pkg::B_Q_HIT;
            fgbq_pkg::B_Q_HIT: begin
                if (r_hits == HW'(MAX_HITS)) begin
                    n_stb   = 1'b1;
                    n_st    = fgbq_pkg::ST_HIT;
                    n_fi    = r_hidx;
                    n_last  = 1'b1;
                    n_tr    = 1'b1;
                    n_state = fgbq_pkg::B_IDLE;
                end else begin
                    n_stb  = r_hold;
                    n_st   = fgbq_pkg::ST_HIT;
                    n_fi   = r_hidx;
                    n_last = 1'b0;
                    n_hold = 1'b1;
                    n_hidx = sto_rdata;
                    n_hits = r_hits + HW'(1);
                    if ({1'b0, r_s} + 5'd1 < {1'b0, r_n}) begin
                        n_s     = r_s + CW'(1);
                        n_state = fgbq_pkg::B_Q_SLOT;
                    end else if (r_y != r_cmd.y1) begin
                        n_y     = r_y + XW'(1);
                        n_state = fgbq_pkg::B_Q_RD;
                    end else if (r_x != r_cmd.x1) begin
                        n_x     = r_x + XW'(1);
                        n_y     = r_cmd.y0;
                        n_state = fgbq_pkg::B_Q_RD;
                    end else begin
                        n_state = fgbq_pkg::B_Q_END;
                    end
                end
            end
            fgbq_pkg::B_Q_END: begin
                n_stb   = 1'b1;
                n_last  = 1'b1;
                n_st    = r_hold ? fgbq_pkg::ST_HIT : fgbq_pkg::ST_EMPTY;
                n_fi    = r_hold ? r_hidx : '0;
                n_state = fgbq_pkg::B_IDLE;
            end
            default: n_state = fgbq_pkg::B_IDLE;
        endcase
    end

    assign o_init          = r_state == fgbq_pkg::B_INIT;
    assign o_strobe        = r_stb;
    assign o_status        = r_st;
    assign o_feature_index = r_fi;
    assign o_last          = r_last;
    assign o_truncated     = r_tr && r_stb;
endmodule

/* sv/feature_grid_bucket_query.sv */
// Top level of the feature grid bucket query block.
// Depends on fgbq_pkg, fgbq_front, fgbq_queue, fgbq_back.
//
// After reset the block sweeps the fill-count RAM, one cell per cycle, over
// all GRID_CELLS*GRID_CELLS cells with busy high. The front end takes one item
// at a time into a two-entry queue; busy stays high from the transfer until
// the front hands its command to the queue, and longer while the queue is full.
// The back end reads the cell count, then checks and writes it on an insert,
// answers a reject or an empty query from idle, and on a query reads each
// window cell's count, then each stored slot, then ends; a clear sweeps all cells.
// Results leave on o_strobe one per cycle at most; the receiver cannot stall.
module feature_grid_bucket_query #(
    parameter int CELL_PIXELS   = fgbq_pkg::CELL_PIXELS_DEF,
    parameter int GRID_CELLS    = fgbq_pkg::GRID_CELLS_DEF,
    parameter int CELL_CAPACITY = fgbq_pkg::CELL_CAPACITY_DEF,
    parameter int MAX_HITS      = fgbq_pkg::MAX_HITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [12:0] i_u_pixel,
    input  logic signed [12:0] i_v_pixel,
    input  logic [10:0]        i_radius_pixels,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [11:0]        o_feature_index,
    output logic               o_last,
    output logic               o_truncated
);
    logic           init, q_full, q_empty, push, pop;
    fgbq_pkg::t_cmd f_cmd, q_cmd;

    fgbq_front #(.CELL_PIXELS(CELL_PIXELS), .GRID_CELLS(GRID_CELLS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hold          (init),
        .start           (start),
        .i_mode          (i_mode),
        .i_u_pixel       (i_u_pixel),
        .i_v_pixel       (i_v_pixel),
        .i_radius_pixels (i_radius_pixels),
        .o_busy          (busy),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (f_cmd)
    );

    fgbq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    fgbq_back #(
        .GRID_CELLS    (GRID_CELLS),
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_HITS      (MAX_HITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_init          (init),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_feature_index (o_feature_index),
        .o_last          (o_last),
        .o_truncated     (o_truncated)
    );
endmodule

/* sv/fgbq_checker.sv */
// Port-level checker for the feature grid bucket query block, bound to the top.
// Depends on fgbq_pkg and feature_grid_bucket_query.
module fgbq_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic [11:0] o_feature_index,
    input logic        o_last,
    input logic        o_truncated
);
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == fgbq_pkg::ST_STORED || o_status == fgbq_pkg::ST_OUTSIDE
        || o_status == fgbq_pkg::ST_FULL || o_status == fgbq_pkg::ST_EMPTY
        || o_status == fgbq_pkg::ST_CLEARED) |-> o_last)
        else $error("single-result status without last");

    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_truncated |-> o_strobe && o_last && o_status == fgbq_pkg::ST_HIT)
        else $error("truncation outside final hit");

    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == fgbq_pkg::ST_EMPTY || o_status == fgbq_pkg::ST_CLEARED)
        |-> o_feature_index == 12'd0)
        else $error("nonzero index on empty or cleared");

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");
endmodule

bind feature_grid_bucket_query fgbq_assert u_fgbq_assert (.*);
